[hdl/pcrg_pkg.sv]
// ----------------------------------------------------------------------------
// pcrg_pkg: shared definitions for the pinhole camera ray generator
// Fixed-point formats, register codes, reset values and vector helpers.
// ----------------------------------------------------------------------------
package pcrg_pkg;

    localparam int COMPONENT_BITS = 21;
    localparam int FRACTION_BITS  = 15;
    localparam int VEC_W          = 3 * COMPONENT_BITS;
    localparam int REG_W          = 63;

    localparam logic signed [63:0] COMP_MAX = (64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] COMP_MIN = -(64'sd1 <<< (COMPONENT_BITS - 1));

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;

    typedef enum logic [3:0] {
        REG_RIGHT,
        REG_UP,
        REG_FORWARD,
        REG_POSITION,
        REG_INV_HALF_W,
        REG_INV_HALF_H,
        REG_SCALE_X,
        REG_SCALE_Y
    } cfg_index_t;

    localparam logic [REG_W-1:0] RIGHT_RST    = 63'd1048576;
    localparam logic [REG_W-1:0] UP_RST       = 63'd68719476736;
    localparam logic [REG_W-1:0] FORWARD_RST  = 63'd2251799813685248;
    localparam logic [REG_W-1:0] POSITION_RST = 63'd0;
    localparam logic [23:0]      INV_HALF_RST = 24'hFFFFFF;
    localparam logic [19:0]      SCALE_RST    = 20'd32768;

    // Mode and ray limit riding along the front stages
    typedef struct packed {
        logic        mode;
        logic [31:0] limit;
    } fside_t;

    // Fields that ride along the back stages untouched
    typedef struct packed {
        logic [REG_W-1:0] ox;
        logic [REG_W-1:0] oy;
        logic [31:0]      limit;
        logic [2:0]       neg;
    } side_t;

    function automatic comp_t comp_get(input logic [REG_W-1:0] v, input int i);
        return v[i*COMPONENT_BITS +: COMPONENT_BITS];
    endfunction

    function automatic comp_t sat_comp(input logic signed [63:0] v);
        comp_t r;
        if (v > COMP_MAX) r = COMPONENT_BITS'(COMP_MAX);
        else if (v < COMP_MIN) r = COMPONENT_BITS'(COMP_MIN);
        else r = COMPONENT_BITS'(v);
        return r;
    endfunction

    // Round half away from zero, shift s >= 1
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
        logic [63:0] half;
        logic [63:0] m;
        logic signed [63:0] r;
        half = 64'd1 << (s - 1);
        if (v >= 0) begin
            r = $signed((64'(v) + half) >> s);
        end
        else begin
            m = 64'(-v);
            r = -$signed((m + half) >> s);
        end
        return r;
    endfunction

    function automatic logic [REG_W-1:0] pack3(input comp_t c0, input comp_t c1,
                                               input comp_t c2);
        return REG_W'({c2, c1, c0});
    endfunction

endpackage

[hdl/pinhole_camera_ray_generator.sv]
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator: pipelined primary ray generation
// Screen position in, normalized camera ray with reciprocal and offsets out.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers on a rising edge with start high and
//   busy low. busy stays low, so a new item can enter on every cycle.
//   Results: done pulses for one cycle with all result ports valid; the
//   receiver must take them then, there is no back pressure.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Write only while no item is in flight; ray_origin reads camera_position.
// Pipeline: 14 front stages (scaling, axis products, normalizing shift,
//   squares), 32 square root stages of one result bit each, one stage per
//   quotient bit for the direction divide and for the reciprocal divide.
// Throughput: one ray per cycle, every stage is a full pipeline register.
// Reset: clears all pipeline valid bits and restores the default camera.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_generator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic [19:0]                pixel_x,
    input  logic [19:0]                pixel_y,
    input  logic [31:0]                ray_limit,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [3:0]                 cfg_index,
    input  logic [pcrg_pkg::REG_W-1:0] cfg_data,
    output logic                       done,
    output logic [pcrg_pkg::REG_W-1:0] ray_origin,
    output logic [pcrg_pkg::REG_W-1:0] ray_direction,
    output logic [pcrg_pkg::REG_W-1:0] inverse_direction,
    output logic [pcrg_pkg::REG_W-1:0] x_offset_direction,
    output logic [pcrg_pkg::REG_W-1:0] y_offset_direction,
    output logic [31:0]                ray_max
);
    import pcrg_pkg::*;

    localparam int CB       = COMPONENT_BITS;
    localparam int FB       = FRACTION_BITS;
    localparam int PROD_W   = 44;
    localparam int T_W      = 46;
    localparam int CX0_W    = FB + 14;
    localparam int M_W      = CX0_W + 21;
    localparam int CX_W     = 34;
    localparam int P_W      = CX_W + CB + 2;
    localparam int SXR_W    = CB + 22;
    localparam int OFS_W    = P_W + 1;
    localparam int SH_W     = 6;
    localparam int NM_W     = 31;
    localparam int SQ_STEPS = 32;
    localparam int NORM_W   = 32;
    localparam int D1_W     = FB + 33;
    localparam int Q1_W     = FB + 1;
    localparam int RC_W     = ((FB > CB) ? 2 * FB : 2 * CB) + 2;
    localparam int Q2_W     = CB - 1;
    localparam int FRONT    = 14;
    localparam int LAT      = 50 + FB + CB;

    localparam logic signed [T_W-1:0] ONE32 = {{(T_W-33){1'b0}}, 1'b1, 32'd0};

    // ---------------- configuration ----------------
    logic [REG_W-1:0] cam_right_reg, cam_up_reg, cam_fwd_reg, cam_pos_reg;
    logic [23:0]      ihw_reg, ihh_reg;
    logic [19:0]      scl_x_reg, scl_y_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_right_reg <= RIGHT_RST;
            cam_up_reg    <= UP_RST;
            cam_fwd_reg   <= FORWARD_RST;
            cam_pos_reg   <= POSITION_RST;
            ihw_reg       <= INV_HALF_RST;
            ihh_reg       <= INV_HALF_RST;
            scl_x_reg     <= SCALE_RST;
            scl_y_reg     <= SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_RIGHT:      cam_right_reg <= cfg_data;
                REG_UP:         cam_up_reg    <= cfg_data;
                REG_FORWARD:    cam_fwd_reg   <= cfg_data;
                REG_POSITION:   cam_pos_reg   <= cfg_data;
                REG_INV_HALF_W: ihw_reg       <= cfg_data[23:0];
                REG_INV_HALF_H: ihh_reg       <= cfg_data[23:0];
                REG_SCALE_X:    scl_x_reg     <= cfg_data[19:0];
                REG_SCALE_Y:    scl_y_reg     <= cfg_data[19:0];
                default:        ;
            endcase
        end
    end

    // ---------------- valid bits ----------------
    logic [FRONT:1]    vf_reg;
    logic [SQ_STEPS:1] vs_reg;
    logic [Q1_W:0]     v1_reg;
    logic              vd_reg;
    logic [Q2_W:0]     v2_reg;
    logic              vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
            vs_reg <= '0;
            v1_reg <= '0;
            vd_reg <= 1'b0;
            v2_reg <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= {vf_reg[FRONT-1:1], start && !busy};
            vs_reg <= {vs_reg[SQ_STEPS-1:1], vf_reg[FRONT]};
            v1_reg <= {v1_reg[Q1_W-1:0], vs_reg[SQ_STEPS]};
            vd_reg <= v1_reg[Q1_W];
            v2_reg <= {v2_reg[Q2_W-1:0], vd_reg};
            vo_reg <= v2_reg[Q2_W];
        end
    end

    // ---------------- front stages ----------------
    fside_t                  fs_reg [1:9];
    logic [19:0]             s1_px_reg, s1_py_reg;
    logic [PROD_W-1:0]       s2_ux_reg, s2_uy_reg;
    logic signed [T_W-1:0]   s3_tx_reg, s3_ty_reg;
    logic signed [CX0_W-1:0] s4_cx0_reg, s4_cy0_reg;
    logic signed [M_W-1:0]   s5_mx_reg, s5_my_reg;
    logic signed [CX_W-1:0]  s6_cx_reg, s6_cy_reg;
    logic signed [P_W-1:0]   s7_pr_reg [0:2];
    logic signed [P_W-1:0]   s7_pu_reg [0:2];
    logic signed [P_W-1:0]   s7_pf_reg [0:2];
    logic signed [SXR_W-1:0] s7_sxr_reg [0:2];
    logic signed [SXR_W-1:0] s7_syu_reg [0:2];
    logic signed [P_W-1:0]   s8_p_reg [0:2];
    logic signed [SXR_W-1:0] s8_sxr_reg [0:2];
    logic signed [SXR_W-1:0] s8_syu_reg [0:2];
    logic [P_W-1:0]          s9_mag_reg [0:2];
    logic [2:0]              s9_neg_reg;
    logic signed [OFS_W-1:0] s9_oxs_reg [0:2];
    logic signed [OFS_W-1:0] s9_oys_reg [0:2];
    logic [P_W-1:0]          s10_mag_reg [0:2];
    logic [P_W-1:0]          s10_mx_reg;
    side_t                   s10_sd_reg;
    logic [P_W-1:0]          s11_mag_reg [0:2];
    logic [SH_W-1:0]         s11_len_reg;
    side_t                   s11_sd_reg;
    logic [NM_W-1:0]         s12_nm_reg [0:2];
    side_t                   s12_sd_reg;
    logic [61:0]             s13_sq_reg [0:2];
    logic [NM_W-1:0]         s13_nm_reg [0:2];
    side_t                   s13_sd_reg;

    logic [P_W-1:0]  mx_next;
    logic [SH_W-1:0] len_next;
    comp_t           ox_c [0:2];
    comp_t           oy_c [0:2];

    always_comb
    begin
        mx_next = s9_mag_reg[0];
        if (s9_mag_reg[1] > mx_next) mx_next = s9_mag_reg[1];
        if (s9_mag_reg[2] > mx_next) mx_next = s9_mag_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            ox_c[i] = sat_comp(rshr(64'(s9_oxs_reg[i]), FB));
            oy_c[i] = sat_comp(rshr(64'(s9_oys_reg[i]), FB));
        end
        // bit length of the largest magnitude
        len_next = '0;
        for (int b = 0; b < P_W; b++)
        begin
            if (s10_mx_reg[b]) len_next = SH_W'(b + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        fs_reg[1]  <= '{mode: mode, limit: ray_limit};
        s1_px_reg  <= pixel_x;
        s1_py_reg  <= pixel_y;
        for (int k = 2; k <= 9; k++) fs_reg[k] <= fs_reg[k-1];

        s2_ux_reg  <= s1_px_reg * ihw_reg;
        s2_uy_reg  <= s1_py_reg * ihh_reg;
        s3_tx_reg  <= $signed({2'b00, s2_ux_reg}) - ONE32;
        s3_ty_reg  <= ONE32 - $signed({2'b00, s2_uy_reg});
        s4_cx0_reg <= CX0_W'(rshr(64'(s3_tx_reg), 32 - FB));
        s4_cy0_reg <= CX0_W'(rshr(64'(s3_ty_reg), 32 - FB));
        s5_mx_reg  <= s4_cx0_reg * $signed({1'b0, scl_x_reg});
        s5_my_reg  <= s4_cy0_reg * $signed({1'b0, scl_y_reg});
        s6_cx_reg  <= CX_W'(rshr(64'(s5_mx_reg), FB));
        s6_cy_reg  <= CX_W'(rshr(64'(s5_my_reg), FB));

        for (int i = 0; i < 3; i++)
        begin
            s7_pr_reg[i]  <= s6_cx_reg * comp_get(cam_right_reg, i);
            s7_pu_reg[i]  <= s6_cy_reg * comp_get(cam_up_reg, i);
            s7_pf_reg[i]  <= P_W'(comp_get(cam_fwd_reg, i)) <<< FB;
            s7_sxr_reg[i] <= $signed({1'b0, scl_x_reg}) * comp_get(cam_right_reg, i);
            s7_syu_reg[i] <= $signed({1'b0, scl_y_reg}) * comp_get(cam_up_reg, i);
            s8_p_reg[i]   <= s7_pr_reg[i] + s7_pu_reg[i] + s7_pf_reg[i];
            s8_sxr_reg[i] <= s7_sxr_reg[i];
            s8_syu_reg[i] <= s7_syu_reg[i];
            s9_neg_reg[i] <= s8_p_reg[i][P_W-1];
            s9_mag_reg[i] <= s8_p_reg[i][P_W-1] ? P_W'(-s8_p_reg[i]) : P_W'(s8_p_reg[i]);
            s9_oxs_reg[i] <= OFS_W'(s8_p_reg[i]) + OFS_W'(s8_sxr_reg[i]);
            s9_oys_reg[i] <= OFS_W'(s8_p_reg[i]) + OFS_W'(s8_syu_reg[i]);
            s10_mag_reg[i] <= s9_mag_reg[i];
            s11_mag_reg[i] <= s10_mag_reg[i];
            // bring the largest magnitude into [2^30, 2^31)
            if (s11_len_reg > SH_W'(NM_W))
                s12_nm_reg[i] <= NM_W'(s11_mag_reg[i] >> (s11_len_reg - SH_W'(NM_W)));
            else
                s12_nm_reg[i] <= NM_W'(s11_mag_reg[i] << (SH_W'(NM_W) - s11_len_reg));
            s13_sq_reg[i] <= 62'(s12_nm_reg[i]) * 62'(s12_nm_reg[i]);
            s13_nm_reg[i] <= s12_nm_reg[i];
        end

        s10_mx_reg       <= mx_next;
        s10_sd_reg.limit <= fs_reg[9].limit;
        s10_sd_reg.neg   <= s9_neg_reg;
        s10_sd_reg.ox    <= fs_reg[9].mode ? pack3(ox_c[0], ox_c[1], ox_c[2]) : '0;
        s10_sd_reg.oy    <= fs_reg[9].mode ? pack3(oy_c[0], oy_c[1], oy_c[2]) : '0;
        s11_len_reg      <= len_next;
        s11_sd_reg       <= s10_sd_reg;
        s12_sd_reg       <= s11_sd_reg;
        s13_sd_reg       <= s12_sd_reg;
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [63:0]     sq_v_reg  [0:SQ_STEPS];
    logic [63:0]     sq_r_reg  [0:SQ_STEPS];
    logic [NM_W-1:0] sq_nm_reg [0:SQ_STEPS][0:2];
    side_t           sq_sd_reg [0:SQ_STEPS];
    logic [63:0]     sq_v_next [1:SQ_STEPS];
    logic [63:0]     sq_r_next [1:SQ_STEPS];

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            logic [63:0] bitv;
            logic [64:0] trial;
            bitv  = 64'd1 << (62 - 2 * k);
            trial = {1'b0, sq_r_reg[k]} + {1'b0, bitv};
            if ({1'b0, sq_v_reg[k]} >= trial)
            begin
                sq_v_next[k+1] = sq_v_reg[k] - trial[63:0];
                sq_r_next[k+1] = (sq_r_reg[k] >> 1) + bitv;
            end
            else
            begin
                sq_v_next[k+1] = sq_v_reg[k];
                sq_r_next[k+1] = sq_r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_v_reg[0]  <= 64'(s13_sq_reg[0]) + 64'(s13_sq_reg[1]) + 64'(s13_sq_reg[2]);
        sq_r_reg[0]  <= '0;
        sq_nm_reg[0] <= s13_nm_reg;
        sq_sd_reg[0] <= s13_sd_reg;
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            sq_v_reg[k]  <= sq_v_next[k];
            sq_r_reg[k]  <= sq_r_next[k];
            sq_nm_reg[k] <= sq_nm_reg[k-1];
            sq_sd_reg[k] <= sq_sd_reg[k-1];
        end
    end

    // ---------------- direction divide: magnitude / norm ----------------
    logic [D1_W-1:0]   d1_rem_reg  [0:Q1_W][0:2];
    logic [Q1_W-1:0]   d1_q_reg    [0:Q1_W][0:2];
    logic [NORM_W-1:0] d1_norm_reg [0:Q1_W];
    side_t             d1_sd_reg   [0:Q1_W];
    logic [D1_W-1:0]   d1_rem_next [1:Q1_W][0:2];
    logic [Q1_W-1:0]   d1_q_next   [1:Q1_W][0:2];

    always_comb
    begin
        for (int j = 0; j < Q1_W; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [D1_W:0] dv;
                dv = (D1_W+1)'(d1_norm_reg[j]) << (FB - j);
                d1_rem_next[j+1][i] = d1_rem_reg[j][i];
                d1_q_next[j+1][i]   = d1_q_reg[j][i];
                if ({1'b0, d1_rem_reg[j][i]} >= dv)
                begin
                    d1_rem_next[j+1][i]        = d1_rem_reg[j][i] - D1_W'(dv);
                    d1_q_next[j+1][i][FB - j]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d1_norm_reg[0] <= sq_r_reg[SQ_STEPS][NORM_W-1:0];
        d1_sd_reg[0]   <= sq_sd_reg[SQ_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            d1_rem_reg[0][i] <= (D1_W'(sq_nm_reg[SQ_STEPS][i]) << FB)
                              + D1_W'(sq_r_reg[SQ_STEPS][NORM_W-1:1]);
            d1_q_reg[0][i]   <= '0;
        end
        for (int j = 1; j <= Q1_W; j++)
        begin
            d1_rem_reg[j]  <= d1_rem_next[j];
            d1_q_reg[j]    <= d1_q_next[j];
            d1_norm_reg[j] <= d1_norm_reg[j-1];
            d1_sd_reg[j]   <= d1_sd_reg[j-1];
        end
    end

    // ---------------- signed, saturated direction ----------------
    comp_t dr_dir_reg [0:2];
    side_t dr_sd_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [63:0] d;
            d = d1_sd_reg[Q1_W].neg[i] ? -$signed(64'(d1_q_reg[Q1_W][i]))
                                       : $signed(64'(d1_q_reg[Q1_W][i]));
            // zero camera point: no direction
            dr_dir_reg[i] <= (d1_norm_reg[Q1_W] != '0) ? sat_comp(d) : '0;
        end
        dr_sd_reg <= d1_sd_reg[Q1_W];
    end

    // ---------------- reciprocal divide: 2^(2F) / |direction| ----------------
    logic [RC_W-1:0] d2_rem_reg [0:Q2_W][0:2];
    logic [CB-1:0]   d2_a_reg   [0:Q2_W][0:2];
    logic [Q2_W-1:0] d2_q_reg   [0:Q2_W][0:2];
    logic [2:0]      d2_ovf_reg [0:Q2_W];
    comp_t           d2_dir_reg [0:Q2_W][0:2];
    side_t           d2_sd_reg  [0:Q2_W];
    logic [RC_W-1:0] d2_rem_next [1:Q2_W][0:2];
    logic [Q2_W-1:0] d2_q_next   [1:Q2_W][0:2];
    logic [CB-1:0]   a_c   [0:2];
    logic [RC_W-1:0] num_c [0:2];
    logic [2:0]      ovf_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_c[i]   = dr_dir_reg[i][CB-1] ? CB'(-dr_dir_reg[i]) : CB'(dr_dir_reg[i]);
            num_c[i] = (RC_W'(1) << (2 * FB)) + RC_W'(a_c[i] >> 1);
            // quotient beyond the component range, also taken for a zero direction
            ovf_c[i] = num_c[i] >= (RC_W'(a_c[i]) << (CB - 1));
        end
        for (int j = 0; j < Q2_W; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [RC_W-1:0] dv;
                dv = RC_W'(d2_a_reg[j][i]) << (CB - 2 - j);
                d2_rem_next[j+1][i] = d2_rem_reg[j][i];
                d2_q_next[j+1][i]   = d2_q_reg[j][i];
                if (d2_rem_reg[j][i] >= dv)
                begin
                    d2_rem_next[j+1][i]           = d2_rem_reg[j][i] - dv;
                    d2_q_next[j+1][i][CB - 2 - j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d2_rem_reg[0][i] <= num_c[i];
            d2_a_reg[0][i]   <= a_c[i];
            d2_q_reg[0][i]   <= '0;
        end
        d2_ovf_reg[0] <= ovf_c;
        d2_dir_reg[0] <= dr_dir_reg;
        d2_sd_reg[0]  <= dr_sd_reg;
        for (int j = 1; j <= Q2_W; j++)
        begin
            d2_rem_reg[j] <= d2_rem_next[j];
            d2_q_reg[j]   <= d2_q_next[j];
            d2_a_reg[j]   <= d2_a_reg[j-1];
            d2_ovf_reg[j] <= d2_ovf_reg[j-1];
            d2_dir_reg[j] <= d2_dir_reg[j-1];
            d2_sd_reg[j]  <= d2_sd_reg[j-1];
        end
    end

    // ---------------- output register ----------------
    logic [REG_W-1:0] dir_out_reg, inv_out_reg, ox_out_reg, oy_out_reg;
    logic [31:0]      max_out_reg;
    comp_t            inv_c [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp_t m;
            m = d2_ovf_reg[Q2_W][i] ? CB'(COMP_MAX) : CB'(d2_q_reg[Q2_W][i]);
            inv_c[i] = d2_dir_reg[Q2_W][i][CB-1] ? -m : m;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_out_reg <= pack3(d2_dir_reg[Q2_W][0], d2_dir_reg[Q2_W][1], d2_dir_reg[Q2_W][2]);
        inv_out_reg <= pack3(inv_c[0], inv_c[1], inv_c[2]);
        ox_out_reg  <= d2_sd_reg[Q2_W].ox;
        oy_out_reg  <= d2_sd_reg[Q2_W].oy;
        max_out_reg <= d2_sd_reg[Q2_W].limit;
    end

    assign done               = vo_reg;
    assign ray_origin         = cam_pos_reg & REG_W'({VEC_W{1'b1}});
    assign ray_direction      = dir_out_reg;
    assign inverse_direction  = inv_out_reg;
    assign x_offset_direction = ox_out_reg;
    assign y_offset_direction = oy_out_reg;
    assign ray_max            = max_out_reg;

    // ---------------- assertions ----------------
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item did not complete after the pipeline latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted item");

    a_plain_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        (vf_reg[9] && !fs_reg[9].mode) |=> (s10_sd_reg.ox == '0 && s10_sd_reg.oy == '0))
        else $error("offset directions not cleared in plain mode");

    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        vf_reg[12] |-> (s12_nm_reg[0][NM_W-1] || s12_nm_reg[1][NM_W-1]
                        || s12_nm_reg[2][NM_W-1]
                        || (s12_nm_reg[0] == '0 && s12_nm_reg[1] == '0
                            && s12_nm_reg[2] == '0)))
        else $error("normalizing shift left the largest magnitude out of range");

    a_zero_dir_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ray_direction == '0) |->
            inverse_direction == pack3(CB'(COMP_MAX), CB'(COMP_MAX), CB'(COMP_MAX)))
        else $error("zero direction without saturated reciprocal");

endmodule

[sim/pinhole_camera_ray_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator_tb: self-checking bench for the ray generator
// Drives screen positions under several camera setups and sender gap rates,
// predicts each ray in fixed point and compares every result port.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_generator_tb;

    import pcrg_pkg::*;

    localparam int CW        = COMPONENT_BITS;
    localparam int FB        = FRACTION_BITS;
    localparam int LATENCY   = 50 + FRACTION_BITS + COMPONENT_BITS;
    localparam int STALL_MAX = 4000;

    typedef longint unsigned ulong_t;

    typedef struct {
        logic [REG_W-1:0] origin;
        logic [REG_W-1:0] dir;
        logic [REG_W-1:0] inv;
        logic [REG_W-1:0] xoff;
        logic [REG_W-1:0] yoff;
        logic [31:0]      rmax;
    } ray_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic mode;
    logic [19:0] pixel_x;
    logic [19:0] pixel_y;
    logic [31:0] ray_limit;
    logic cfg_valid;
    logic cfg_ready;
    logic [3:0] cfg_index;
    logic [REG_W-1:0] cfg_data;
    logic done;
    logic [REG_W-1:0] ray_origin;
    logic [REG_W-1:0] ray_direction;
    logic [REG_W-1:0] inverse_direction;
    logic [REG_W-1:0] x_offset_direction;
    logic [REG_W-1:0] y_offset_direction;
    logic [31:0] ray_max;

    // camera shadow
    logic [REG_W-1:0] cam_right = RIGHT_RST;
    logic [REG_W-1:0] cam_up    = UP_RST;
    logic [REG_W-1:0] cam_fwd   = FORWARD_RST;
    logic [REG_W-1:0] cam_pos   = POSITION_RST;
    logic [23:0] inv_w  = INV_HALF_RST;
    logic [23:0] inv_h  = INV_HALF_RST;
    logic [19:0] sx     = SCALE_RST;
    logic [19:0] sy     = SCALE_RST;

    ray_t pending_rays[$];
    int   mismatches = 0;
    int   idle_pct   = 0;
    int   stall_cnt  = 0;

    pinhole_camera_ray_generator i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .pixel_x           (pixel_x),
        .pixel_y           (pixel_y),
        .ray_limit         (ray_limit),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .ray_origin        (ray_origin),
        .ray_direction     (ray_direction),
        .inverse_direction (inverse_direction),
        .x_offset_direction(x_offset_direction),
        .y_offset_direction(y_offset_direction),
        .ray_max           (ray_max)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- math
    function automatic longint lane(input logic [REG_W-1:0] v, input int i);
        logic signed [CW-1:0] t;
        t = v[i*CW +: CW];
        return longint'(t);
    endfunction

    function automatic longint clamp_lane(input longint v);
        longint hi;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        ulong_t half;
        half = 64'd1 << (s - 1);
        if (v >= 0) return longint'((ulong_t'(v) + half) >> s);
        return -longint'((ulong_t'(-v) + half) >> s);
    endfunction

    function automatic ulong_t floor_sqrt(input ulong_t v);
        ulong_t root;
        ulong_t b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic ray_t trace_ray(input logic m, input logic [19:0] px,
                                       input logic [19:0] py, input logic [31:0] lim);
        ray_t r;
        longint cx;
        longint cy;
        longint pt[3];
        longint d;
        longint lim_c;
        ulong_t mag[3];
        ulong_t peak;
        ulong_t sum;
        ulong_t nrm;
        ulong_t q;
        ulong_t a;
        int len;
        cx = round_shift(longint'(px) * longint'(inv_w) - (longint'(1) <<< 32), 32 - FB);
        cx = round_shift(cx * longint'(sx), FB);
        cy = round_shift((longint'(1) <<< 32) - longint'(py) * longint'(inv_h), 32 - FB);
        cy = round_shift(cy * longint'(sy), FB);
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = cx * lane(cam_right, i) + cy * lane(cam_up, i)
                  + (lane(cam_fwd, i) <<< FB);
            mag[i] = (pt[i] < 0) ? ulong_t'(-pt[i]) : ulong_t'(pt[i]);
            if (mag[i] > peak) peak = mag[i];
        end
        len = 0;
        while (len < 64 && (peak >> len) != 0) len++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (peak == 0) mag[i] = 0;
            else if (len > 31) mag[i] = mag[i] >> (len - 31);
            else if (len < 31) mag[i] = mag[i] << (31 - len);
            sum = sum + mag[i] * mag[i];
        end
        nrm = floor_sqrt(sum);
        lim_c = (longint'(1) <<< (CW - 1)) - 1;
        r = '{default: '0};
        for (int i = 0; i < 3; i++)
        begin
            d = 0;
            if (nrm != 0)
            begin
                q = ((mag[i] << FB) + nrm / 2) / nrm;
                d = (pt[i] < 0) ? -longint'(q) : longint'(q);
            end
            d = clamp_lane(d);
            r.dir[i*CW +: CW] = d[CW-1:0];
            if (d == 0)
                r.inv[i*CW +: CW] = lim_c[CW-1:0];
            else
            begin
                a = (d < 0) ? ulong_t'(-d) : ulong_t'(d);
                q = ((64'd1 << (2 * FB)) + a / 2) / a;
                if (q > ulong_t'(lim_c)) q = ulong_t'(lim_c);
                d = (d < 0) ? -longint'(q) : longint'(q);
                r.inv[i*CW +: CW] = d[CW-1:0];
            end
            if (m)
            begin
                d = clamp_lane(round_shift(pt[i] + longint'(sx) * lane(cam_right, i), FB));
                r.xoff[i*CW +: CW] = d[CW-1:0];
                d = clamp_lane(round_shift(pt[i] + longint'(sy) * lane(cam_up, i), FB));
                r.yoff[i*CW +: CW] = d[CW-1:0];
            end
        end
        r.origin = cam_pos;
        r.rmax   = lim;
        return r;
    endfunction

    // ------------------------------------------------------------- drivers
    task automatic set_reg(input cfg_index_t idx, input logic [REG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RIGHT:      cam_right = v;
            REG_UP:         cam_up    = v;
            REG_FORWARD:    cam_fwd   = v;
            REG_POSITION:   cam_pos   = v;
            REG_INV_HALF_W: inv_w     = v[23:0];
            REG_INV_HALF_H: inv_h     = v[23:0];
            REG_SCALE_X:    sx        = v[19:0];
            REG_SCALE_Y:    sy        = v[19:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // start stays high across back-to-back transfers; the idle_pct gap loop lowers it
    task automatic send_ray(input logic m, input logic [19:0] px,
                            input logic [19:0] py, input logic [31:0] lim);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        mode      <= m;
        pixel_x   <= px;
        pixel_y   <= py;
        ray_limit <= lim;
        do @(posedge clk); while (busy);
        pending_rays.push_back(trace_ray(m, px, py, lim));
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rays.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [REG_W-1:0] rand_vec();
        logic [REG_W-1:0] v;
        logic [31:0] c;
        v = '0;
        for (int i = 0; i < 3; i++)
        begin
            c = $urandom >> $urandom_range(11, 31);
            if ($urandom_range(0, 1)) c = -c;
            v[i*CW +: CW] = c[CW-1:0];
        end
        return v;
    endfunction

    task automatic random_rays(input int n);
        logic [19:0] px;
        logic [19:0] py;
        for (int k = 0; k < n; k++)
        begin
            px = ($urandom_range(0, 9) < 7) ? 20'($urandom_range(0, 8191)) : 20'($urandom);
            py = ($urandom_range(0, 9) < 7) ? 20'($urandom_range(0, 8191)) : 20'($urandom);
            send_ray(1'($urandom), px, py, $urandom);
        end
    endtask

    // --------------------------------------------------------------- tests
    task automatic test_directed();
        send_ray(1'b0, 20'd0, 20'd0, 32'd0);
        send_ray(1'b1, 20'd0, 20'd0, 32'hFFFF_FFFF);
        send_ray(1'b1, 20'hFFFFF, 20'hFFFFF, 32'h0001_0000);
        send_ray(1'b0, 20'hFFFFF, 20'd0, 32'hFFFF_FFFF);
        send_ray(1'b1, 20'd0, 20'hFFFFF, 32'h8000_0000);
        send_ray(1'b1, 20'd1, 20'd1, 32'd1);
        send_ray(1'b0, 20'h80000, 20'h7FFFF, 32'h5555_5555);
        send_ray(1'b1, 20'hAAAAA, 20'h55555, 32'hAAAA_AAAA);
        drain();
        // degenerate camera: zero point, zero direction, saturated reciprocal
        set_reg(REG_FORWARD, '0);
        set_reg(REG_RIGHT, '0);
        set_reg(REG_UP, '0);
        send_ray(1'b1, 20'd1234, 20'd4321, 32'd7);
        send_ray(1'b0, 20'hFFFFF, 20'hFFFFF, 32'd9);
        drain();
        // full-scale axes and scales: offsets saturate, one lane dominates
        set_reg(REG_RIGHT, REG_W'({1'b0, {21{1'b1}}, 21'h0FFFFF, 21'h0FFFFF}));
        set_reg(REG_UP, {21'h100000, 21'h0FFFFF, 21'h100000});
        set_reg(REG_FORWARD, {21'h0FFFFF, 21'h000001, 21'h100000});
        set_reg(REG_POSITION, {REG_W{1'b1}});
        set_reg(REG_SCALE_X, REG_W'(20'hFFFFF));
        set_reg(REG_SCALE_Y, REG_W'(20'hFFFFF));
        set_reg(REG_INV_HALF_W, REG_W'(24'hFFFFFF));
        set_reg(REG_INV_HALF_H, REG_W'(24'h000000));
        send_ray(1'b1, 20'hFFFFF, 20'd0, 32'd1);
        send_ray(1'b1, 20'd0, 20'hFFFFF, 32'd2);
        send_ray(1'b0, 20'd256, 20'd256, 32'd3);
        drain();
        set_reg(REG_SCALE_X, REG_W'(20'd0));
        set_reg(REG_SCALE_Y, REG_W'(20'd0));
        set_reg(REG_INV_HALF_W, REG_W'(24'd0));
        set_reg(REG_INV_HALF_H, REG_W'(24'hFFFFFF));
        set_reg(cfg_index_t'(REG_SCALE_Y + 1), {REG_W{1'b1}});
        send_ray(1'b1, 20'hFFFFF, 20'hFFFFF, 32'd4);
        send_ray(1'b0, 20'd0, 20'd0, 32'd5);
        drain();
    endtask

    task automatic test_random_camera(input int n);
        int w;
        int h;
        w = $urandom_range(2, 4096);
        h = $urandom_range(2, 4096);
        set_reg(REG_RIGHT, rand_vec());
        set_reg(REG_UP, rand_vec());
        set_reg(REG_FORWARD, rand_vec());
        set_reg(REG_POSITION, REG_W'({$urandom, $urandom}));
        set_reg(REG_INV_HALF_W, REG_W'(($urandom_range(0, 3) == 0) ? 24'($urandom)
                                       : 24'(((longint'(1) <<< 32) / w) >> 8)));
        set_reg(REG_INV_HALF_H, REG_W'(($urandom_range(0, 3) == 0) ? 24'($urandom)
                                       : 24'(((longint'(1) <<< 32) / h) >> 8)));
        set_reg(REG_SCALE_X, REG_W'(20'($urandom >> $urandom_range(12, 24))));
        set_reg(REG_SCALE_Y, REG_W'(20'($urandom >> $urandom_range(12, 24))));
        random_rays(n);
        drain();
    endtask

    task automatic test_gap_phases();
        int rates[4] = '{0, 60, 33, 0};
        foreach (rates[i])
        begin
            idle_pct = rates[i];
            test_random_camera(350);
        end
        idle_pct = 0;
    endtask

    // -------------------------------------------------------------- checker
    always @(posedge clk)
    begin
        ray_t e;
        if (rst_n && done)
        begin
            if (pending_rays.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected, dir %h", $realtime,
                             ray_direction);
            end
            else
            begin
                e = pending_rays.pop_front();
                if (ray_origin !== e.origin || ray_direction !== e.dir
                    || inverse_direction !== e.inv || x_offset_direction !== e.xoff
                    || y_offset_direction !== e.yoff || ray_max !== e.rmax)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: ray mismatch", $realtime);
                        $display("  origin exp %h got %h", e.origin, ray_origin);
                        $display("  dir    exp %h got %h", e.dir, ray_direction);
                        $display("  inv    exp %h got %h", e.inv, inverse_direction);
                        $display("  xoff   exp %h got %h", e.xoff, x_offset_direction);
                        $display("  yoff   exp %h got %h", e.yoff, y_offset_direction);
                        $display("  max    exp %h got %h", e.rmax, ray_max);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (done || (start && !busy) || (cfg_valid && cfg_ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX)
        begin
            $display("pinhole_camera_ray_generator verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        mode      = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        ray_limit = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RIGHT;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_gap_phases();
        drain();
        if (mismatches == 0)
            $display("pinhole_camera_ray_generator verification clean");
        else
            $display("pinhole_camera_ray_generator verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/pcrg_pkg.sv
hdl/pinhole_camera_ray_generator.sv
sim/pinhole_camera_ray_generator_tb.sv
